### sv/pmid_pkg.sv
// ----------------------------------------------------------------------------
// pmid_pkg: shared types and constants for the minimum image distance block
// Widths of the cell, position and result fields, candidate and sideband
// records, and the configuration register codes.
// ----------------------------------------------------------------------------
package pmid_pkg;

  localparam int SHIFT_SPAN = 1;
  localparam int NSH        = 2 * SHIFT_SPAN + 1;
  localparam int NCAND      = NSH * NSH * NSH;
  // The unshifted candidate leads the list so that it wins every tie.
  localparam int NLIST      = NCAND + 1;
  localparam int LEVELS     = $clog2(NLIST);

  localparam int CELL_W = 27;
  localparam int POS_W  = 24;
  localparam int FRAC_W = 16;
  localparam int DU_W   = FRAC_W + 4;
  localparam int ACC_W  = CELL_W + DU_W + 3;
  localparam int RND_W  = ACC_W - FRAC_W;
  localparam int CART_W = 27;
  localparam int SQ_W   = 2 * CART_W;
  localparam int D2_W   = SQ_W + 2;
  localparam int RB     = D2_W / 2;
  localparam int DSQ_W  = 40;
  localparam int RES_W  = 28;
  localparam int DIFF_W = 18;
  localparam int IDX_W  = 3;

  localparam logic signed [RND_W-1:0] CART_MAX = RND_W'((1 <<< (CART_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] CART_MIN = -RND_W'(1 <<< (CART_W - 1));
  localparam logic signed [DU_W-1:0]  DIFF_MAX = DU_W'(131071);
  localparam logic signed [DU_W-1:0]  DIFF_MIN = -DU_W'(65536);

  typedef enum logic [IDX_W-1:0] {
    REG_AX = 3'd0,
    REG_BX = 3'd1,
    REG_BY = 3'd2,
    REG_CX = 3'd3,
    REG_CY = 3'd4,
    REG_CZ = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] ax;
    logic signed [CELL_W-1:0] bx;
    logic signed [CELL_W-1:0] by;
    logic signed [CELL_W-1:0] cx;
    logic signed [CELL_W-1:0] cy;
    logic signed [CELL_W-1:0] cz;
  } cell_t;

  typedef struct packed {
    logic signed [POS_W-1:0] first_u;
    logic signed [POS_W-1:0] first_v;
    logic signed [POS_W-1:0] first_w;
    logic signed [POS_W-1:0] second_u;
    logic signed [POS_W-1:0] second_v;
    logic signed [POS_W-1:0] second_w;
  } pos_t;

  typedef struct packed {
    logic [D2_W-1:0]         d2;
    logic signed [DU_W-1:0]  du;
    logic signed [DU_W-1:0]  dv;
    logic signed [DU_W-1:0]  dw;
  } cand_t;

  typedef struct packed {
    logic [DSQ_W-1:0]          dsq;
    logic signed [DIFF_W-1:0]  du;
    logic signed [DIFF_W-1:0]  dv;
    logic signed [DIFF_W-1:0]  dw;
  } side_t;

  // Number of live entries at a level of the minimum tree.
  function automatic int level_cnt(input int l);
    return (NLIST + (1 << l) - 1) >> l;
  endfunction

  function automatic logic signed [DIFF_W-1:0] sat_diff(input logic signed [DU_W-1:0] d);
    logic signed [DU_W-1:0] c;
    c = (d > DIFF_MAX) ? DIFF_MAX : ((d < DIFF_MIN) ? DIFF_MIN : d);
    return DIFF_W'(c);
  endfunction

endpackage

### sv/pmid_cart.sv
// ----------------------------------------------------------------------------
// pmid_cart: candidate squared lengths
// Reduces the position difference, maps every shifted candidate through the
// cell matrix and forms its exact squared length over six register stages.
// ----------------------------------------------------------------------------
module pmid_cart (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  pmid_pkg::pos_t       in_pos,
  input  pmid_pkg::cell_t      cell_regs,
  output logic                 out_valid,
  output pmid_pkg::cand_t      out_list [pmid_pkg::NLIST]
);

  typedef struct packed {
    logic [pmid_pkg::FRAC_W-1:0] u;
    logic [pmid_pkg::FRAC_W-1:0] v;
    logic [pmid_pkg::FRAC_W-1:0] w;
  } frac_t;

  localparam int NJK = pmid_pkg::NSH * pmid_pkg::NSH;
  localparam int C0  = (pmid_pkg::SHIFT_SPAN * pmid_pkg::NSH + pmid_pkg::SHIFT_SPAN)
                       * pmid_pkg::NSH + pmid_pkg::SHIFT_SPAN;

  function automatic logic signed [pmid_pkg::CART_W-1:0] rnd_clamp(
    input logic signed [pmid_pkg::ACC_W-1:0] x);
    logic signed [pmid_pkg::ACC_W-1:0] t;
    logic signed [pmid_pkg::RND_W-1:0] r;
    t = x + (pmid_pkg::ACC_W'(1) <<< (pmid_pkg::FRAC_W - 1));
    r = pmid_pkg::RND_W'(t >>> pmid_pkg::FRAC_W);
    if (r > pmid_pkg::CART_MAX) r = pmid_pkg::CART_MAX;
    else if (r < pmid_pkg::CART_MIN) r = pmid_pkg::CART_MIN;
    return pmid_pkg::CART_W'(r);
  endfunction

  logic [5:0] vld_r;
  frac_t f1_r, f2_r, f3_r, f4_r, f5_r;

  logic signed [pmid_pkg::ACC_W-1:0] xoff_r [pmid_pkg::NCAND];
  logic signed [pmid_pkg::ACC_W-1:0] yoff_r [NJK];
  logic signed [pmid_pkg::ACC_W-1:0] zoff_r [pmid_pkg::NSH];

  logic signed [pmid_pkg::ACC_W-1:0] pax_r, pbx_r, pcx_r, pby_r, pcy_r, pcz_r;
  logic signed [pmid_pkg::ACC_W-1:0] xs_r [pmid_pkg::NCAND];
  logic signed [pmid_pkg::ACC_W-1:0] ys_r [NJK];
  logic signed [pmid_pkg::ACC_W-1:0] zs_r [pmid_pkg::NSH];
  logic signed [pmid_pkg::CART_W-1:0] xc_r [pmid_pkg::NCAND];
  logic signed [pmid_pkg::CART_W-1:0] yc_r [NJK];
  logic signed [pmid_pkg::CART_W-1:0] zc_r [pmid_pkg::NSH];
  logic [pmid_pkg::SQ_W-1:0] sqx_r [pmid_pkg::NCAND];
  logic [pmid_pkg::SQ_W-1:0] sqy_r [NJK];
  logic [pmid_pkg::SQ_W-1:0] sqz_r [pmid_pkg::NSH];
  pmid_pkg::cand_t list_r [pmid_pkg::NLIST];

  logic signed [pmid_pkg::ACC_W-1:0] axe, bxe, bye, cxe, cye, cze;
  frac_t f1_nxt;

  assign axe = pmid_pkg::ACC_W'(cell_regs.ax);
  assign bxe = pmid_pkg::ACC_W'(cell_regs.bx);
  assign bye = pmid_pkg::ACC_W'(cell_regs.by);
  assign cxe = pmid_pkg::ACC_W'(cell_regs.cx);
  assign cye = pmid_pkg::ACC_W'(cell_regs.cy);
  assign cze = pmid_pkg::ACC_W'(cell_regs.cz);

  // Keeping the low fraction bits of the difference is the reduction to [0,1).
  assign f1_nxt.u = pmid_pkg::FRAC_W'(in_pos.second_u - in_pos.first_u);
  assign f1_nxt.v = pmid_pkg::FRAC_W'(in_pos.second_v - in_pos.first_v);
  assign f1_nxt.w = pmid_pkg::FRAC_W'(in_pos.second_w - in_pos.first_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  // Offsets track cell registers; user changes them only when idle, unchecked.
  always_ff @(posedge clk) begin
    for (int ii = 0; ii < pmid_pkg::NSH; ii++) begin
      for (int jj = 0; jj < pmid_pkg::NSH; jj++) begin
        for (int kk = 0; kk < pmid_pkg::NSH; kk++) begin
          xoff_r[(ii * pmid_pkg::NSH + jj) * pmid_pkg::NSH + kk] <=
            pmid_pkg::ACC_W'((pmid_pkg::ACC_W'(ii - pmid_pkg::SHIFT_SPAN) * axe
                            + pmid_pkg::ACC_W'(jj - pmid_pkg::SHIFT_SPAN) * bxe
                            + pmid_pkg::ACC_W'(kk - pmid_pkg::SHIFT_SPAN) * cxe)
                            <<< pmid_pkg::FRAC_W);
        end
      end
    end
    for (int jj = 0; jj < pmid_pkg::NSH; jj++) begin
      for (int kk = 0; kk < pmid_pkg::NSH; kk++) begin
        yoff_r[jj * pmid_pkg::NSH + kk] <=
          pmid_pkg::ACC_W'((pmid_pkg::ACC_W'(jj - pmid_pkg::SHIFT_SPAN) * bye
                          + pmid_pkg::ACC_W'(kk - pmid_pkg::SHIFT_SPAN) * cye)
                          <<< pmid_pkg::FRAC_W);
      end
    end
    for (int kk = 0; kk < pmid_pkg::NSH; kk++) begin
      zoff_r[kk] <= pmid_pkg::ACC_W'((pmid_pkg::ACC_W'(kk - pmid_pkg::SHIFT_SPAN) * cze)
                                     <<< pmid_pkg::FRAC_W);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= f1_nxt;
      f2_r <= f1_r;
      f3_r <= f2_r;
      f4_r <= f3_r;
      f5_r <= f4_r;

      pax_r <= pmid_pkg::ACC_W'(cell_regs.ax * $signed({1'b0, f1_r.u}));
      pbx_r <= pmid_pkg::ACC_W'(cell_regs.bx * $signed({1'b0, f1_r.v}));
      pcx_r <= pmid_pkg::ACC_W'(cell_regs.cx * $signed({1'b0, f1_r.w}));
      pby_r <= pmid_pkg::ACC_W'(cell_regs.by * $signed({1'b0, f1_r.v}));
      pcy_r <= pmid_pkg::ACC_W'(cell_regs.cy * $signed({1'b0, f1_r.w}));
      pcz_r <= pmid_pkg::ACC_W'(cell_regs.cz * $signed({1'b0, f1_r.w}));

      for (int c = 0; c < pmid_pkg::NCAND; c++) begin
        xs_r[c]  <= pax_r + pbx_r + pcx_r + xoff_r[c];
        xc_r[c]  <= rnd_clamp(xs_r[c]);
        sqx_r[c] <= pmid_pkg::SQ_W'(xc_r[c] * xc_r[c]);
      end
      for (int c = 0; c < NJK; c++) begin
        ys_r[c]  <= pby_r + pcy_r + yoff_r[c];
        yc_r[c]  <= rnd_clamp(ys_r[c]);
        sqy_r[c] <= pmid_pkg::SQ_W'(yc_r[c] * yc_r[c]);
      end
      for (int c = 0; c < pmid_pkg::NSH; c++) begin
        zs_r[c]  <= pcz_r + zoff_r[c];
        zc_r[c]  <= rnd_clamp(zs_r[c]);
        sqz_r[c] <= pmid_pkg::SQ_W'(zc_r[c] * zc_r[c]);
      end

      list_r[0].d2 <= pmid_pkg::D2_W'(sqx_r[C0])
                    + pmid_pkg::D2_W'(sqy_r[C0 / pmid_pkg::NSH % NJK])
                    + pmid_pkg::D2_W'(sqz_r[C0 % pmid_pkg::NSH]);
      list_r[0].du <= pmid_pkg::DU_W'($signed({1'b0, f5_r.u}));
      list_r[0].dv <= pmid_pkg::DU_W'($signed({1'b0, f5_r.v}));
      list_r[0].dw <= pmid_pkg::DU_W'($signed({1'b0, f5_r.w}));
      for (int ii = 0; ii < pmid_pkg::NSH; ii++) begin
        for (int jj = 0; jj < pmid_pkg::NSH; jj++) begin
          for (int kk = 0; kk < pmid_pkg::NSH; kk++) begin
            list_r[1 + (ii * pmid_pkg::NSH + jj) * pmid_pkg::NSH + kk].d2 <=
                pmid_pkg::D2_W'(sqx_r[(ii * pmid_pkg::NSH + jj) * pmid_pkg::NSH + kk])
              + pmid_pkg::D2_W'(sqy_r[jj * pmid_pkg::NSH + kk])
              + pmid_pkg::D2_W'(sqz_r[kk]);
            list_r[1 + (ii * pmid_pkg::NSH + jj) * pmid_pkg::NSH + kk].du <=
                pmid_pkg::DU_W'($signed({1'b0, f5_r.u}))
              + pmid_pkg::DU_W'((ii - pmid_pkg::SHIFT_SPAN) * (1 <<< pmid_pkg::FRAC_W));
            list_r[1 + (ii * pmid_pkg::NSH + jj) * pmid_pkg::NSH + kk].dv <=
                pmid_pkg::DU_W'($signed({1'b0, f5_r.v}))
              + pmid_pkg::DU_W'((jj - pmid_pkg::SHIFT_SPAN) * (1 <<< pmid_pkg::FRAC_W));
            list_r[1 + (ii * pmid_pkg::NSH + jj) * pmid_pkg::NSH + kk].dw <=
                pmid_pkg::DU_W'($signed({1'b0, f5_r.w}))
              + pmid_pkg::DU_W'((kk - pmid_pkg::SHIFT_SPAN) * (1 <<< pmid_pkg::FRAC_W));
          end
        end
      end
    end
  end

  assign out_valid = vld_r[5];
  assign out_list  = list_r;

endmodule

### sv/pmid_mintree.sv
// ----------------------------------------------------------------------------
// pmid_mintree: registered minimum tree
// Picks the first candidate of smallest squared length, one tree level a
// register stage. On equal lengths the earlier entry is kept.
// ----------------------------------------------------------------------------
module pmid_mintree (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  pmid_pkg::cand_t  in_list [pmid_pkg::NLIST],
  output logic             out_valid,
  output pmid_pkg::cand_t  out_best
);

  pmid_pkg::cand_t lvl_r [pmid_pkg::LEVELS][pmid_pkg::NLIST];
  pmid_pkg::cand_t src   [pmid_pkg::LEVELS][pmid_pkg::NLIST];
  logic [pmid_pkg::LEVELS-1:0] vld_r;

  always_comb begin
    src[0] = in_list;
    for (int l = 1; l < pmid_pkg::LEVELS; l++) begin
      src[l] = lvl_r[l-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[pmid_pkg::LEVELS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    int a;
    int b;
    int na;
    if (en) begin
      for (int l = 0; l < pmid_pkg::LEVELS; l++) begin
        na = pmid_pkg::level_cnt(l);
        for (int e = 0; e < pmid_pkg::NLIST; e++) begin
          a = (2 * e < pmid_pkg::NLIST) ? 2 * e : 0;
          b = (2 * e + 1 < pmid_pkg::NLIST) ? 2 * e + 1 : 0;
          if (2 * e + 1 < na) begin
            lvl_r[l][e] <= (src[l][b].d2 < src[l][a].d2) ? src[l][b] : src[l][a];
          end else if (2 * e < na) begin
            lvl_r[l][e] <= src[l][a];
          end else begin
            lvl_r[l][e] <= '0;
          end
        end
      end
    end
  end

  assign out_valid = vld_r[pmid_pkg::LEVELS-1];
  assign out_best  = lvl_r[pmid_pkg::LEVELS-1][0];

endmodule

### sv/pmid_isqrt.sv
// ----------------------------------------------------------------------------
// pmid_isqrt: pipelined integer square root
// Digit-by-digit binary square root, one result bit per register stage,
// with the result sideband carried alongside.
// ----------------------------------------------------------------------------
module pmid_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [pmid_pkg::D2_W-1:0]  in_rad,
  input  pmid_pkg::side_t            in_side,
  output logic                       out_valid,
  output logic [pmid_pkg::RB-1:0]    out_root,
  output pmid_pkg::side_t            out_side
);

  logic [pmid_pkg::D2_W-1:0] rad_r  [pmid_pkg::RB+1];
  logic [pmid_pkg::RB+1:0]   rem_r  [pmid_pkg::RB+1];
  logic [pmid_pkg::RB-1:0]   root_r [pmid_pkg::RB+1];
  pmid_pkg::side_t           side_r [pmid_pkg::RB+1];
  logic [pmid_pkg::RB:0]     vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[pmid_pkg::RB-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= in_rad;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 0; s < pmid_pkg::RB; s++) begin : g_step
    logic [pmid_pkg::RB+1:0] rem_sh;
    logic [pmid_pkg::RB+1:0] trial;
    logic                    ge;

    assign rem_sh = {rem_r[s][pmid_pkg::RB-1:0], rad_r[s][pmid_pkg::D2_W-1 -: 2]};
    assign trial  = {root_r[s], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[s+1]  <= rad_r[s] << 2;
        rem_r[s+1]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[s+1] <= {root_r[s][pmid_pkg::RB-2:0], ge};
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_valid = vld_r[pmid_pkg::RB];
  assign out_root  = root_r[pmid_pkg::RB];
  assign out_side  = side_r[pmid_pkg::RB];

endmodule

### sv/periodic_min_image_distance_top.sv
// ----------------------------------------------------------------------------
// periodic_min_image_distance_top: minimum image distance in a triclinic cell
// Streams position pairs in, returns the shortest periodic image distance,
// its squared value and the winning fractional difference.
//
//   channel   dir  beat contents (low bits first)
//   in_       in   first_u, first_v, first_w, second_u, second_v, second_w
//   out_      out  dist_squared, dist_res, diff_u, diff_v, diff_w
//   cfg_      in   cfg_index selects a cell register, cfg_data is its value
//
// One pair is taken every cycle while the output is not stalled. Each pair
// passes through the registered candidate arithmetic, the minimum tree, the
// rounding of its squared length and the square root, in that order.
// The whole pipeline moves together and freezes while a result waits at the
// output, so a stall loses and repeats nothing. Reset clears the valid bits
// and loads the unit cube into the cell registers.
// ----------------------------------------------------------------------------
module periodic_min_image_distance_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_u, first_v, first_w, second_u, second_v, second_w (24 bits each)
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // dist_squared[39:0], dist_res[67:40], diff_u, diff_v, diff_w (18 each), pad
  output logic [127:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [pmid_pkg::IDX_W-1:0]  cfg_index,
  input  logic [pmid_pkg::CELL_W-1:0] cfg_data
);

  pmid_pkg::cell_t  cell_r;
  pmid_pkg::pos_t   pos;
  pmid_pkg::cand_t  list [pmid_pkg::NLIST];
  pmid_pkg::cand_t  best;
  pmid_pkg::side_t  side;
  pmid_pkg::side_t  res_side;
  logic             en;
  logic             list_valid;
  logic             best_valid;
  logic [pmid_pkg::D2_W-pmid_pkg::FRAC_W:0] dsq_full;
  logic [pmid_pkg::RB-1:0] root;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.ax <= pmid_pkg::CELL_W'(1 <<< pmid_pkg::FRAC_W);
      cell_r.bx <= '0;
      cell_r.by <= pmid_pkg::CELL_W'(1 <<< pmid_pkg::FRAC_W);
      cell_r.cx <= '0;
      cell_r.cy <= '0;
      cell_r.cz <= pmid_pkg::CELL_W'(1 <<< pmid_pkg::FRAC_W);
    end else if (cfg_valid) begin
      unique case (pmid_pkg::cfg_reg_t'(cfg_index))
        pmid_pkg::REG_AX: cell_r.ax <= cfg_data;
        pmid_pkg::REG_BX: cell_r.bx <= cfg_data;
        pmid_pkg::REG_BY: cell_r.by <= cfg_data;
        pmid_pkg::REG_CX: cell_r.cx <= cfg_data;
        pmid_pkg::REG_CY: cell_r.cy <= cfg_data;
        pmid_pkg::REG_CZ: cell_r.cz <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign pos.first_u  = in_tdata[23:0];
  assign pos.first_v  = in_tdata[47:24];
  assign pos.first_w  = in_tdata[71:48];
  assign pos.second_u = in_tdata[95:72];
  assign pos.second_v = in_tdata[119:96];
  assign pos.second_w = in_tdata[143:120];

  pmid_cart u_cart (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_pos    (pos),
    .cell_regs (cell_r),
    .out_valid (list_valid),
    .out_list  (list)
  );

  pmid_mintree u_tree (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (list_valid),
    .in_list   (list),
    .out_valid (best_valid),
    .out_best  (best)
  );

  // Round the winning squared length to Q.16 and saturate the reported fields.
  assign dsq_full = (pmid_pkg::D2_W-pmid_pkg::FRAC_W+1)'(
                      ({1'b0, best.d2} + (pmid_pkg::D2_W+1)'(1 <<< (pmid_pkg::FRAC_W - 1)))
                      >> pmid_pkg::FRAC_W);
  assign side.dsq = (dsq_full > (pmid_pkg::D2_W-pmid_pkg::FRAC_W+1)'({pmid_pkg::DSQ_W{1'b1}}))
                  ? {pmid_pkg::DSQ_W{1'b1}} : pmid_pkg::DSQ_W'(dsq_full);
  assign side.du  = pmid_pkg::sat_diff(best.du);
  assign side.dv  = pmid_pkg::sat_diff(best.dv);
  assign side.dw  = pmid_pkg::sat_diff(best.dw);

  pmid_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (best_valid),
    .in_rad    (best.d2),
    .in_side   (side),
    .out_valid (out_tvalid),
    .out_root  (root),
    .out_side  (res_side)
  );

  assign out_tdata = {6'b0, res_side.dw, res_side.dv, res_side.du,
                      pmid_pkg::RES_W'(root), res_side.dsq};

  // The root squared never exceeds the rounded squared length by over half a step.
  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (64'(out_tdata[67:40]) * 64'(out_tdata[67:40]))
                   <= ((64'(out_tdata[39:0]) << 16) + 64'd32768))
    else $error("square root larger than the squared distance allows");

  a_diff_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[85:68]) >= -18'sd65536)
                && ($signed(out_tdata[103:86]) >= -18'sd65536)
                && ($signed(out_tdata[121:104]) >= -18'sd65536))
    else $error("winning difference below its range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while the pipeline is frozen");

endmodule

### sim/periodic_min_image_distance_top_tb.sv
// ----------------------------------------------------------------------------
// periodic_min_image_distance_top_tb: self-checking bench for the minimum
// image distance block.
// A directed table and random position pairs are streamed through the block
// under several cell settings and handshake idling patterns. Every output
// beat is compared field by field against a typed row or a bit-accurate predictor.
// ----------------------------------------------------------------------------
module periodic_min_image_distance_top_tb;

  localparam logic [pmid_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [pmid_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 60;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [39:0] dsq;
    logic [27:0] res;
    logic [17:0] du;
    logic [17:0] dv;
    logic [17:0] dw;
  } dist_t;

  typedef struct {
    pmid_pkg::pos_t pos;
    bit             typed;
    dist_t          want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [pmid_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [pmid_pkg::CELL_W-1:0] cfg_data = '0;

  idle_mode_t idle_mode = IDLE_NONE;
  dist_t      expected_dist_q[$];
  int         mismatches = 0;

  // Cell held by the predictor.
  longint m_ax = 65536, m_bx = 0, m_by = 65536, m_cx = 0, m_cy = 0, m_cz = 65536;

  periodic_min_image_distance_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint clamp64(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Cartesian squared length (Q.32) of a fractional difference in Q.16.
  function automatic longint cart_len_sq(longint du, longint dv, longint dw);
    longint x, y, z;
    x = clamp64((m_ax * du + m_bx * dv + m_cx * dw + 32768) >>> 16, -67108864, 67108863);
    y = clamp64((m_by * dv + m_cy * dw + 32768) >>> 16, -67108864, 67108863);
    z = clamp64((m_cz * dw + 32768) >>> 16, -67108864, 67108863);
    return x * x + y * y + z * z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic dist_t predict_min_image(pmid_pkg::pos_t p);
    dist_t  r;
    longint fu, fv, fw, bu, bv, bw, best, d;
    longint unsigned rt;
    fu = (longint'(p.second_u) - longint'(p.first_u)) & 64'hFFFF;
    fv = (longint'(p.second_v) - longint'(p.first_v)) & 64'hFFFF;
    fw = (longint'(p.second_w) - longint'(p.first_w)) & 64'hFFFF;
    bu = fu; bv = fv; bw = fw;
    best = cart_len_sq(fu, fv, fw);
    for (int i = -pmid_pkg::SHIFT_SPAN; i <= pmid_pkg::SHIFT_SPAN; i++)
      for (int j = -pmid_pkg::SHIFT_SPAN; j <= pmid_pkg::SHIFT_SPAN; j++)
        for (int k = -pmid_pkg::SHIFT_SPAN; k <= pmid_pkg::SHIFT_SPAN; k++) begin
          d = cart_len_sq(fu + i * 65536, fv + j * 65536, fw + k * 65536);
          if (d < best) begin
            best = d;
            bu = fu + i * 65536;
            bv = fv + j * 65536;
            bw = fw + k * 65536;
          end
        end
    d = (best + 32768) >>> 16;
    r.dsq = (d > 64'd1099511627775) ? 40'hFF_FFFF_FFFF : d[39:0];
    rt = int_sqrt(best);
    r.res = (rt > 64'd268435455) ? 28'hFFF_FFFF : rt[27:0];
    bu = clamp64(bu, -65536, 131071);
    bv = clamp64(bv, -65536, 131071);
    bw = clamp64(bw, -65536, 131071);
    r.du = bu[17:0];
    r.dv = bv[17:0];
    r.dw = bw[17:0];
    return r;
  endfunction

  function automatic pmid_pkg::pos_t mk_pos(int fu, int fv, int fw, int su, int sv, int sw);
    pmid_pkg::pos_t p;
    p.first_u = 24'(fu); p.first_v = 24'(fv); p.first_w = 24'(fw);
    p.second_u = 24'(su); p.second_v = 24'(sv); p.second_w = 24'(sw);
    return p;
  endfunction

  function automatic dist_t mk_dist(longint dsq, longint res, int du, int dv, int dw);
    dist_t r;
    r.dsq = 40'(dsq); r.res = 28'(res); r.du = 18'(du); r.dv = 18'(dv); r.dw = 18'(dw);
    return r;
  endfunction

  function automatic logic [23:0] rand_extreme();
    case ($urandom_range(3))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  // Nearby pairs in half the draws, which exercise the shift search, plus
  // full-range noise and extreme coordinates.
  function automatic pmid_pkg::pos_t rand_pair();
    pmid_pkg::pos_t p;
    int             sel;
    sel = $urandom_range(9);
    if (sel < 5) begin
      p.first_u = 24'($signed($urandom_range(1048576)) - 524288);
      p.first_v = 24'($signed($urandom_range(1048576)) - 524288);
      p.first_w = 24'($signed($urandom_range(1048576)) - 524288);
      p.second_u = 24'(p.first_u + $signed($urandom_range(196608)) - 98304);
      p.second_v = 24'(p.first_v + $signed($urandom_range(196608)) - 98304);
      p.second_w = 24'(p.first_w + $signed($urandom_range(196608)) - 98304);
    end else if (sel < 8) begin
      p.first_u = 24'($urandom()); p.first_v = 24'($urandom()); p.first_w = 24'($urandom());
      p.second_u = 24'($urandom()); p.second_v = 24'($urandom());
      p.second_w = 24'($urandom());
    end else begin
      p.first_u = rand_extreme(); p.first_v = rand_extreme(); p.first_w = rand_extreme();
      p.second_u = rand_extreme(); p.second_v = rand_extreme();
      p.second_w = rand_extreme();
    end
    return p;
  endfunction

  task automatic write_cell(logic [pmid_pkg::IDX_W-1:0] idx, longint value);
    logic signed [pmid_pkg::CELL_W-1:0] v;
    v = value[pmid_pkg::CELL_W-1:0];
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pmid_pkg::REG_AX: m_ax = v;
      pmid_pkg::REG_BX: m_bx = v;
      pmid_pkg::REG_BY: m_by = v;
      pmid_pkg::REG_CX: m_cx = v;
      pmid_pkg::REG_CY: m_cy = v;
      pmid_pkg::REG_CZ: m_cz = v;
      default: ;
    endcase
  endtask

  task automatic load_cell(longint ax, longint bx, longint by,
                           longint cx, longint cy, longint cz);
    write_cell(pmid_pkg::REG_AX, ax);
    write_cell(pmid_pkg::REG_BX, bx);
    write_cell(pmid_pkg::REG_BY, by);
    write_cell(pmid_pkg::REG_CX, cx);
    write_cell(pmid_pkg::REG_CY, cy);
    write_cell(pmid_pkg::REG_CZ, cz);
  endtask

  task automatic drain();
    while (expected_dist_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pair(pmid_pkg::pos_t p, bit typed, dist_t want);
    if (idle_mode == IDLE_SENDER && $urandom_range(99) < 54 ||
        idle_mode == IDLE_BOTH && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.second_w, p.second_v, p.second_u, p.first_w, p.first_v, p.first_u};
    do @(posedge clk); while (!in_tready);
    expected_dist_q.insert(expected_dist_q.size(), typed ? want : predict_min_image(p));
  endtask

  task automatic send_random(int count);
    dist_t none;
    none = mk_dist(0, 0, 0, 0, 0);
    for (int n = 0; n < count; n++) send_pair(rand_pair(), 1'b0, none);
    in_tvalid <= 1'b0;
  endtask

  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_tready <= ($urandom_range(99) >= 54);
      IDLE_BOTH:     out_tready <= ($urandom_range(99) >= 8);
      default:       out_tready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    dist_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.dsq = out_tdata[39:0];
      got.res = out_tdata[67:40];
      got.du  = out_tdata[85:68];
      got.dv  = out_tdata[103:86];
      got.dw  = out_tdata[121:104];
      if (expected_dist_q.size() == 0) begin
        $error("result beat with no pair outstanding");
        mismatches++;
      end else begin
        want = expected_dist_q.pop_front();
        if (got.dsq != want.dsq) begin
          $error("dist_squared expected %0d got %0d", want.dsq, got.dsq); mismatches++;
        end
        if (got.res != want.res) begin
          $error("dist_res expected %0d got %0d", want.res, got.res); mismatches++;
        end
        if (got.du != want.du) begin
          $error("diff_u expected %h got %h", want.du, got.du); mismatches++;
        end
        if (got.dv != want.dv) begin
          $error("diff_v expected %h got %h", want.dv, got.dv); mismatches++;
        end
        if (got.dw != want.dw) begin
          $error("diff_w expected %h got %h", want.dw, got.dw); mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    dist_t     none;
    none = mk_dist(0, 0, 0, 0, 0);

    // Unit cube after reset: typed rows are readable by hand.
    rows.insert(rows.size(), '{mk_pos(0, 0, 0, 0, 0, 0), 1'b1, mk_dist(0, 0, 0, 0, 0)});
    // Half-cell offset ties with its negative image; the unshifted one stays.
    rows.insert(rows.size(), '{mk_pos(0, 0, 0, 32768, 0, 0), 1'b1,
                               mk_dist(16384, 32768, 32768, 0, 0)});
    // Full-range span reduces to one step below a cell, nearest image is -1.
    rows.insert(rows.size(), '{mk_pos(-8388608, 0, 0, 8388607, 0, 0), 1'b1,
                               mk_dist(0, 1, 18'h3FFFF, 0, 0)});
    rows.insert(rows.size(), '{mk_pos(0, -8388608, 0, 0, 8388607, 0), 1'b1,
                               mk_dist(0, 1, 0, 18'h3FFFF, 0)});
    rows.insert(rows.size(), '{mk_pos(0, 0, -8388608, 0, 0, 8388607), 1'b1,
                               mk_dist(0, 1, 0, 0, 18'h3FFFF)});
    rows.insert(rows.size(),
                '{mk_pos(8388607, 8388607, 8388607, -8388608, -8388608, -8388608),
                  1'b0, none});
    rows.insert(rows.size(),
                '{mk_pos(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608),
                  1'b0, none});
    rows.insert(rows.size(),
                '{mk_pos(8388607, 8388607, 8388607, 8388607, 8388607, 8388607),
                  1'b0, none});
    rows.insert(rows.size(), '{mk_pos(0, 0, 0, 32768, 32768, 32768), 1'b0, none});
    rows.insert(rows.size(), '{mk_pos(0, 0, 0, 32767, 32769, 65535), 1'b0, none});
    rows.insert(rows.size(), '{mk_pos(-1, -1, -1, 0, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_pos(65536, 131072, -65536, 0, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_pos(12345, -54321, 99999, -777, 4242, 1), 1'b0, none});
    rows.insert(rows.size(),
                '{mk_pos(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607),
                  1'b0, none});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_mode = IDLE_NONE;
    foreach (rows[r]) send_pair(rows[r].pos, rows[r].typed, rows[r].want);
    in_tvalid <= 1'b0;
    send_random(150);
    drain();

    // Largest positive cell; writes to spare indexes must be ignored.
    write_cell(REG_SPARE_LO, 67108863);
    write_cell(REG_SPARE_HI, -67108864);
    load_cell(67108863, 67108863, 67108863, 67108863, 67108863, 67108863);
    idle_mode = IDLE_SENDER;
    send_random(150);
    drain();

    load_cell(-67108864, -67108864, -67108864, -67108864, -67108864, -67108864);
    idle_mode = IDLE_RECEIVER;
    send_random(150);
    drain();

    // Skewed triclinic cell with moderate edges.
    load_cell(5 * 65536 + $urandom_range(65535), $urandom_range(262144) - 131072,
              4 * 65536 + $urandom_range(65535), $urandom_range(262144) - 131072,
              $urandom_range(262144) - 131072, 6 * 65536 + $urandom_range(65535));
    idle_mode = IDLE_BOTH;
    send_random(150);
    drain();

    // Degenerate cell: zero and negative edges.
    load_cell(0, -65536, 3 * 65536, 65536, 0, -2 * 65536);
    idle_mode = IDLE_NONE;
    send_random(75);
    while (expected_dist_q.size() != 0) @(posedge clk);
    send_random(75);
    drain();

    load_cell(longint'($signed(27'($urandom()))), longint'($signed(27'($urandom()))),
              longint'($signed(27'($urandom()))), longint'($signed(27'($urandom()))),
              longint'($signed(27'($urandom()))), longint'($signed(27'($urandom()))));
    idle_mode = IDLE_RECEIVER;
    send_random(200);
    drain();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
